/* sv/pcapp_pkg.sv */
package pcapp_pkg;

    localparam int MEAN_W = 24;
    localparam int COEF_W = 16;
    localparam int SMP_W  = 16;
    localparam int DIFF_W = 25;
    localparam int PROD_W = 41;
    localparam int ACC_W  = 48;
    localparam int OUT_W  = 32;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // input item actions
    localparam logic [1:0] ACT_MEAN   = 2'd0;
    localparam logic [1:0] ACT_COEF   = 2'd1;
    localparam logic [1:0] ACT_SAMPLE = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BANDS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COMPS = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NULL  = 2'd2;

    typedef struct packed {
        logic mean_wr;
        logic coef_wr;
        logic smp_take;
        logic diff_en;
        logic mac_rd;
        logic emit_rd;
        logic last;
        logic acc_clr;
    } t_dp_cmd;

    typedef struct packed {
        logic pipe_busy;
        logic out_free;
    } t_dp_stat;

endpackage

/* sv/pcapp_ctrl.sv */
module pcapp_ctrl #(
    parameter int MAX_BANDS      = 256,
    parameter int MAX_COMPONENTS = 16,
    localparam int CNT_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
    localparam int KW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
    localparam int NB_W  = $clog2(MAX_BANDS + 1),
    localparam int NC_W  = $clog2(MAX_COMPONENTS + 1)
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_action,
    input  logic [NB_W-1:0]     i_nb,
    input  logic [NC_W-1:0]     i_nc,
    input  pcapp_pkg::t_dp_stat i_stat,
    output pcapp_pkg::t_dp_cmd  o_cmd,
    output logic [CNT_W-1:0]    o_band,
    output logic [KW-1:0]       o_k
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MEAN,
        S_MAC,
        S_DRAIN,
        S_EMIT
    } t_state;

    t_state            r_state;
    logic [CNT_W-1:0]  r_cnt;
    logic [KW-1:0]     r_k;
    logic              r_end;

    logic              w_take;
    logic              w_last;
    logic [NB_W-1:0]   w_next_cnt;
    logic              w_pix_end;

    always_comb begin
        o_in_ready = (r_state == S_IDLE);
        w_take     = i_in_valid && o_in_ready;
        w_last     = (NC_W'(r_k) == (i_nc - NC_W'(1)));
        w_next_cnt = NB_W'(r_cnt) + NB_W'(1);
        w_pix_end  = (w_next_cnt >= i_nb);

        o_cmd          = '0;
        o_cmd.mean_wr  = w_take && (i_action == pcapp_pkg::ACT_MEAN);
        o_cmd.coef_wr  = w_take && (i_action == pcapp_pkg::ACT_COEF);
        o_cmd.smp_take = w_take && (i_action == pcapp_pkg::ACT_SAMPLE);
        o_cmd.diff_en  = (r_state == S_MEAN);
        o_cmd.mac_rd   = (r_state == S_MAC);
        o_cmd.emit_rd  = (r_state == S_EMIT) && i_stat.out_free;
        o_cmd.last     = w_last;
        o_cmd.acc_clr  = o_cmd.emit_rd && w_last;
        o_band         = r_cnt;
        o_k            = r_k;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_k     <= '0;
            r_end   <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (o_cmd.smp_take) begin
                        r_end   <= w_pix_end;
                        r_cnt   <= w_pix_end ? '0 : CNT_W'(w_next_cnt);
                        r_state <= S_MEAN;
                    end
                end
                S_MEAN: begin
                    r_k     <= '0;
                    r_state <= S_MAC;
                end
                S_MAC: begin
                    if (w_last) begin
                        r_k     <= '0;
                        r_state <= S_DRAIN;
                    end else begin
                        r_k <= r_k + KW'(1);
                    end
                end
                S_DRAIN: begin
                    // wait for the last accumulator write
                    if (!i_stat.pipe_busy) begin
                        r_state <= r_end ? S_EMIT : S_IDLE;
                    end
                end
                S_EMIT: begin
                    if (o_cmd.emit_rd) begin
                        if (w_last) begin
                            r_k     <= '0;
                            r_state <= S_IDLE;
                        end else begin
                            r_k <= r_k + KW'(1);
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

/* sv/pcapp_dpath.sv */
module pcapp_dpath #(
    parameter int MAX_BANDS      = 256,
    parameter int MAX_COMPONENTS = 16,
    localparam int CNT_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1,
    localparam int KW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1,
    localparam int AW    = $clog2(MAX_BANDS * MAX_COMPONENTS)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  pcapp_pkg::t_dp_cmd                 i_cmd,
    output pcapp_pkg::t_dp_stat                o_stat,
    input  logic [CNT_W-1:0]                   i_band,
    input  logic [KW-1:0]                      i_k,
    input  logic [7:0]                         i_band_index,
    input  logic [3:0]                         i_component_index,
    input  logic signed [pcapp_pkg::MEAN_W-1:0] i_load_value,
    input  logic signed [pcapp_pkg::SMP_W-1:0]  i_sample,
    input  logic signed [pcapp_pkg::SMP_W-1:0]  i_null_value,
    output logic                               o_out_valid,
    input  logic                               i_out_ready,
    output logic [3:0]                         o_component_number,
    output logic signed [pcapp_pkg::OUT_W-1:0] o_component_value,
    output logic                               o_is_null,
    output logic                               o_last
);

    localparam int ACC_W = pcapp_pkg::ACC_W;

    // stores
    logic signed [pcapp_pkg::MEAN_W-1:0] r_mean_mem [MAX_BANDS];
    logic signed [pcapp_pkg::COEF_W-1:0] r_coef_mem [MAX_BANDS * MAX_COMPONENTS];
    logic        [ACC_W-1:0]             r_acc_mem  [MAX_COMPONENTS];
    logic        [MAX_COMPONENTS-1:0]    r_acc_vld;
    logic                                r_null_seen;

    // sample stage
    logic signed [pcapp_pkg::MEAN_W-1:0] r_mean_q;
    logic signed [pcapp_pkg::SMP_W-1:0]  r_sample;
    logic        [AW-1:0]                r_base;
    logic signed [pcapp_pkg::DIFF_W-1:0] r_diff;

    // MAC pipeline
    logic                                r_v1;
    logic                                r_v2;
    logic        [KW-1:0]                r_k1;
    logic        [KW-1:0]                r_k2;
    logic signed [pcapp_pkg::COEF_W-1:0] r_coef_q;
    logic signed [pcapp_pkg::PROD_W-1:0] r_prod;
    logic        [ACC_W-1:0]             r_acc_q;
    logic                                r_acc_ok;

    // result path
    logic                                r_ev;
    logic        [KW-1:0]                r_ek;
    logic                                r_elast;
    logic                                r_enull;
    logic                                r_out_vld;
    logic        [3:0]                   r_out_num;
    logic signed [pcapp_pkg::OUT_W-1:0]  r_out_val;
    logic                                r_out_null;
    logic                                r_out_last;

    logic                                w_band_ok;
    logic                                w_comp_ok;
    logic        [AW-1:0]                w_coef_waddr;
    logic        [KW-1:0]                w_acc_raddr;
    logic signed [pcapp_pkg::DIFF_W-1:0] w_diff;
    logic        [ACC_W-1:0]             w_acc_in;
    logic        [ACC_W:0]               w_sum;
    logic        [ACC_W-1:0]             w_sum_sat;
    logic        [ACC_W:0]               w_round;
    logic        [33:0]                  w_q;
    logic signed [pcapp_pkg::OUT_W-1:0]  w_q_sat;
    logic signed [pcapp_pkg::OUT_W-1:0]  w_res_val;

    always_comb begin
        w_band_ok    = int'(i_band_index) < MAX_BANDS;
        w_comp_ok    = int'(i_component_index) < MAX_COMPONENTS;
        w_coef_waddr = AW'(i_band_index) * AW'(MAX_COMPONENTS) + AW'(i_component_index);
        w_acc_raddr  = r_v1 ? r_k1 : i_k;

        w_diff = $signed({r_sample[15], r_sample, 8'd0}) - $signed({r_mean_q[23], r_mean_q});

        // never-written accumulator reads as zero
        w_acc_in  = r_acc_ok ? r_acc_q : '0;
        w_sum     = {w_acc_in[ACC_W-1], w_acc_in} + {{8{r_prod[40]}}, r_prod};
        w_sum_sat = w_sum[ACC_W-1:0];
        if (w_sum[ACC_W] != w_sum[ACC_W-1]) begin
            w_sum_sat = w_sum[ACC_W] ? {1'b1, {(ACC_W-1){1'b0}}} : {1'b0, {(ACC_W-1){1'b1}}};
        end

        // round half up at bit 15, then clamp to 32 bits
        w_round = {w_acc_in[ACC_W-1], w_acc_in} + (ACC_W+1)'(16384);
        w_q     = w_round[ACC_W:15];
        if ((w_q[33:31] == 3'b000) || (w_q[33:31] == 3'b111)) begin
            w_q_sat = w_q[31:0];
        end else begin
            w_q_sat = w_q[33] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        w_res_val = r_enull ? 32'(i_null_value) : w_q_sat;

        o_stat.pipe_busy = r_v1 || r_v2;
        o_stat.out_free  = !r_ev && (!r_out_vld || i_out_ready);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mean_wr && w_band_ok) begin
            r_mean_mem[CNT_W'(i_band_index)] <= i_load_value;
        end
        if (i_cmd.smp_take) begin
            r_mean_q <= r_mean_mem[i_band];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.coef_wr && w_band_ok && w_comp_ok) begin
            r_coef_mem[w_coef_waddr] <= i_load_value[pcapp_pkg::COEF_W-1:0];
        end
        if (i_cmd.mac_rd) begin
            r_coef_q <= r_coef_mem[r_base + AW'(i_k)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_v2) begin
            r_acc_mem[r_k2] <= w_sum_sat;
        end
        if (r_v1 || i_cmd.emit_rd) begin
            r_acc_q  <= r_acc_mem[w_acc_raddr];
            r_acc_ok <= r_acc_vld[w_acc_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.smp_take) begin
            r_sample <= i_sample;
            r_base   <= AW'(i_band) * AW'(MAX_COMPONENTS);
        end
        if (i_cmd.diff_en) begin
            r_diff <= w_diff;
        end
        r_k1 <= i_k;
        r_k2 <= r_k1;
        if (r_v1) begin
            r_prod <= r_diff * r_coef_q;
        end
        if (i_cmd.emit_rd) begin
            r_ek    <= i_k;
            r_elast <= i_cmd.last;
            r_enull <= r_null_seen;
        end
        if (r_ev) begin
            r_out_num  <= 4'(r_ek);
            r_out_val  <= w_res_val;
            r_out_null <= r_enull;
            r_out_last <= r_elast;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc_vld   <= '0;
            r_null_seen <= 1'b0;
            r_v1        <= 1'b0;
            r_v2        <= 1'b0;
            r_ev        <= 1'b0;
            r_out_vld   <= 1'b0;
        end else begin
            r_v1 <= i_cmd.mac_rd;
            r_v2 <= r_v1;
            r_ev <= i_cmd.emit_rd;
            if (i_cmd.acc_clr) begin
                r_acc_vld   <= '0;
                r_null_seen <= 1'b0;
            end else begin
                if (r_v2) begin
                    r_acc_vld[r_k2] <= 1'b1;
                end
                if (i_cmd.smp_take && (i_sample == i_null_value)) begin
                    r_null_seen <= 1'b1;
                end
            end
            if (r_ev) begin
                r_out_vld <= 1'b1;
            end else if (i_out_ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_component_number = r_out_num;
    assign o_component_value  = r_out_val;
    assign o_is_null          = r_out_null;
    assign o_last             = r_out_last;

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ev |-> !r_out_vld)
        else $error("result loaded over a pending transfer");

    a_mac_emit_apart: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 || r_v2) |-> !i_cmd.emit_rd)
        else $error("result read while accumulators still update");

    a_clr_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_clr |-> !(r_v1 || r_v2))
        else $error("accumulators cleared during a MAC write");

    a_sample_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.smp_take |-> !(r_v1 || r_v2))
        else $error("sample taken while MAC pipeline busy");

endmodule

/* sv/pca_pixel_projection.sv */
// Channel   | Handshake                   | Payload
// ----------+-----------------------------+-------------------------------------------
// input     | i_in_valid / o_in_ready     | action, band_index, component_index,
//           |                             | load_value, sample
// result    | o_out_valid / i_out_ready   | component_number, component_value,
//           |                             | is_null, last
// config    | i_cfg_wr_en (no wait)       | i_cfg_index, i_cfg_data
//
// Mean and coefficient loads write their stores directly as they are taken.
// A band sample goes through mean read, difference, one multiply-accumulate per
// component through the shared MAC unit, and pipeline drain.
// After the last band, results leave one at a time, each waiting on the one before.
// Synchronous active-low reset clears the control state; the stores need loading.
// A stalled final result holds in the output register while the next item is taken.
module pca_pixel_projection #(
    parameter int MAX_BANDS      = 256,
    parameter int MAX_COMPONENTS = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_rst_n,
    input  logic                                    i_in_valid,
    output logic                                    o_in_ready,
    input  logic [1:0]                              i_action,
    input  logic [7:0]                              i_band_index,
    input  logic [3:0]                              i_component_index,
    input  logic signed [pcapp_pkg::MEAN_W-1:0]     i_load_value,
    input  logic signed [pcapp_pkg::SMP_W-1:0]      i_sample,
    output logic                                    o_out_valid,
    input  logic                                    i_out_ready,
    output logic [3:0]                              o_component_number,
    output logic signed [pcapp_pkg::OUT_W-1:0]      o_component_value,
    output logic                                    o_is_null,
    output logic                                    o_last,
    input  logic                                    i_cfg_wr_en,
    input  logic [pcapp_pkg::CFG_IDX_W-1:0]         i_cfg_index,
    input  logic [pcapp_pkg::CFG_DATA_W-1:0]        i_cfg_data
);

    localparam int CNT_W = (MAX_BANDS > 1) ? $clog2(MAX_BANDS) : 1;
    localparam int KW    = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;
    localparam int NB_W  = $clog2(MAX_BANDS + 1);
    localparam int NC_W  = $clog2(MAX_COMPONENTS + 1);

    logic [8:0]                         r_bands;
    logic [4:0]                         r_comps;
    logic signed [pcapp_pkg::SMP_W-1:0] r_null;

    logic [NB_W-1:0]                    w_nb;
    logic [NC_W-1:0]                    w_nc;
    pcapp_pkg::t_dp_cmd                 w_cmd;
    pcapp_pkg::t_dp_stat                w_stat;
    logic [CNT_W-1:0]                   w_band;
    logic [KW-1:0]                      w_k;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bands <= 9'd1;
            r_comps <= 5'd1;
            r_null  <= '0;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                pcapp_pkg::CFG_BANDS: r_bands <= i_cfg_data[8:0];
                pcapp_pkg::CFG_COMPS: r_comps <= i_cfg_data[4:0];
                pcapp_pkg::CFG_NULL:  r_null  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // clamp counts to 1..MAX
    always_comb begin
        if (r_bands == 9'd0) begin
            w_nb = NB_W'(1);
        end else if (int'(r_bands) > MAX_BANDS) begin
            w_nb = NB_W'(MAX_BANDS);
        end else begin
            w_nb = NB_W'(r_bands);
        end
        if (r_comps == 5'd0) begin
            w_nc = NC_W'(1);
        end else if (int'(r_comps) > MAX_COMPONENTS) begin
            w_nc = NC_W'(MAX_COMPONENTS);
        end else begin
            w_nc = NC_W'(r_comps);
        end
    end

    pcapp_ctrl #(
        .MAX_BANDS      (MAX_BANDS),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_action   (i_action),
        .i_nb       (w_nb),
        .i_nc       (w_nc),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd),
        .o_band     (w_band),
        .o_k        (w_k)
    );

    pcapp_dpath #(
        .MAX_BANDS      (MAX_BANDS),
        .MAX_COMPONENTS (MAX_COMPONENTS)
    ) u_dpath (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (w_cmd),
        .o_stat             (w_stat),
        .i_band             (w_band),
        .i_k                (w_k),
        .i_band_index       (i_band_index),
        .i_component_index  (i_component_index),
        .i_load_value       (i_load_value),
        .i_sample           (i_sample),
        .i_null_value       (r_null),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_component_number (o_component_number),
        .o_component_value  (o_component_value),
        .o_is_null          (o_is_null),
        .o_last             (o_last)
    );

endmodule
